### design/br1rle_pkg.sv
// Shared constants, types and a helper function of the ByteRun1 run-length encoder.
package br1rle_pkg;

   // Block limits
   localparam int MAX_LITERAL = 128;
   localparam int MAX_RUN     = 128;
   localparam int MIN_RUN     = 3;
   localparam int OUT_LANES   = 8;

   // Derived sizes
   localparam int STORE_DEPTH = MAX_LITERAL + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int LANES_W     = 64;
   localparam int COUNT_W     = 4;
   localparam int TOTAL_W     = 17;
   localparam int CMDQ_DEPTH  = 4;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [LANES_W-1:0]    lanes_type;
   typedef logic [CMDQ_PTR_W-1:0] qptr_type;
   typedef logic [CMDQ_PTR_W:0]   qcount_type;

   localparam len_type    MAX_LITERAL_LEN = len_type'(MAX_LITERAL);
   localparam len_type    MAX_RUN_LEN     = len_type'(MAX_RUN);
   localparam len_type    MIN_RUN_LEN     = len_type'(MIN_RUN);
   localparam count_type  LAST_LANE       = count_type'(OUT_LANES - 1);
   localparam count_type  OUT_LANES_CNT   = count_type'(OUT_LANES);
   localparam total_type  TOTAL_MAX       = '1;
   localparam qcount_type CMDQ_FULL       = qcount_type'(CMDQ_DEPTH);

   // Block kinds carried in a command
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE    = 2'd0;
   localparam kind_type KIND_LITERAL = 2'd1;
   localparam kind_type KIND_RUN     = 2'd2;

   // One classified item, as handed from front to back
   typedef struct packed {
      logic     row_start;  // first item of a row
      logic     last;       // item closes the row
      byte_type data;       // the item's raw byte
      kind_type e1_kind;    // block closed by this item
      len_type  e1_len;
      byte_type e1_byte;    // repeated byte of a closed run
      logic     wr_en;      // store write of data
      addr_type wr_addr;
      kind_type fl_kind;    // end-of-row flush block
      len_type  fl_len;
   } cmd_type;

   // One code byte on its way to the packer
   typedef struct packed {
      logic     valid;
      byte_type data;
      logic     step_end;   // last code byte caused by one item
      logic     row_end;    // last code byte of a row
      logic     row_first;  // first code byte of a row
   } byte_stream_type;

   // Control byte of a block: n-1 for a literal, -(n-1) for a run
   function automatic byte_type ctrl_byte(input kind_type kind, input len_type len);
      byte_type minus_one;
      minus_one = byte_type'(len - len_type'(1));
      if (kind == KIND_RUN) begin
         return byte_type'(0) - minus_one;
      end
      return minus_one;
   endfunction

endpackage

### design/byterun1_run_length_encoder_top.sv
// Top level of the ByteRun1 (PackBits) row encoder: front end, command queue, back end, packer.
// An item's code passes the command queue, the back end's command register and output stage and
// the packer's result register; a store write ahead of an end-of-row flush comes between as well.
// The front takes a new item while the queue has room, also while the back end still drains earlier blocks.
// Reset is synchronous and clears all control state; the literal store is not cleared and
// needs no clearing pass, since only entries written in the current row are ever read.
module byterun1_run_length_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_code_lanes,
   output logic [3:0]  rsp_lane_count,
   output logic        rsp_row_finished,
   output logic [16:0] rsp_packed_total
);

   // front to queue
   logic                        q_push;
   br1rle_pkg::cmd_type         q_push_cmd;
   logic                        q_full;

   // queue to back
   logic                        q_pop;
   logic                        q_empty;
   br1rle_pkg::cmd_type         q_head;

   // back to packer
   br1rle_pkg::byte_stream_type code_stream;
   logic                        code_take;

   // Classify each item against the literal/run state and issue one command;
   // hold the input only when the queue is full.
   br1rle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_end_of_row (req_end_of_row),
      .req_stall      (req_stall),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_cmd     (q_push_cmd)
   );

   // Decouple the front from the back so the front keeps taking items
   // while the back drains a literal block.
   br1rle_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Execute commands in order: emit the closed block, write the store,
   // then emit the end-of-row flush block, one code byte per cycle while the packer takes them.
   br1rle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .stream  (code_stream),
      .take    (code_take)
   );

   // Pack code bytes into lanes; close a result when the lanes fill or the
   // item's code ends, and close a result only when the result register is free.
   br1rle_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .stream           (code_stream),
      .take             (code_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_lanes   (rsp_code_lanes),
      .rsp_lane_count   (rsp_lane_count),
      .rsp_row_finished (rsp_row_finished),
      .rsp_packed_total (rsp_packed_total)
   );

endmodule

### design/br1rle_front.sv
// Front end: accepts raw bytes, tracks literal/run state and issues block commands.
module br1rle_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_row,
   output logic                 req_stall,
   input  logic                 q_full,
   output logic                 q_push,
   output br1rle_pkg::cmd_type  q_push_cmd
);

   br1rle_pkg::len_type  fill_ff, fill_in;
   br1rle_pkg::len_type  rstart_ff, rstart_in;
   logic                 runm_ff, runm_in;
   br1rle_pkg::byte_type prev_ff, prev_in;
   logic                 open_ff, open_in;
   br1rle_pkg::len_type  n_val;
   br1rle_pkg::cmd_type  cmd;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_push_cmd = cmd;

   always_comb begin
      cmd         = '0;
      cmd.data    = req_data_byte;
      cmd.last    = req_end_of_row;
      cmd.e1_byte = prev_ff;
      fill_in     = fill_ff;
      rstart_in   = rstart_ff;
      runm_in     = runm_ff;
      open_in     = open_ff;
      prev_in     = req_data_byte;
      n_val       = fill_ff + br1rle_pkg::len_type'(1);

      if (!open_ff) begin
         // open the row with this byte at the store base
         cmd.row_start = 1'b1;
         cmd.wr_en     = 1'b1;
         cmd.wr_addr   = '0;
         fill_in       = br1rle_pkg::len_type'(1);
         rstart_in     = '0;
         runm_in       = 1'b0;
         open_in       = 1'b1;
      end else if (!runm_ff) begin
         cmd.wr_en   = 1'b1;
         cmd.wr_addr = br1rle_pkg::addr_type'(fill_ff);
         fill_in     = n_val;
         if (n_val > br1rle_pkg::MAX_LITERAL_LEN) begin
            // store full: close the literal block, restart with this byte
            cmd.e1_kind = br1rle_pkg::KIND_LITERAL;
            cmd.e1_len  = fill_ff;
            cmd.wr_addr = '0;
            fill_in     = br1rle_pkg::len_type'(1);
            rstart_in   = '0;
         end else if (req_data_byte == prev_ff) begin
            if ((n_val - rstart_ff) >= br1rle_pkg::MIN_RUN_LEN) begin
               if (rstart_ff != '0) begin
                  // split off the literal bytes in front of the run
                  cmd.e1_kind = br1rle_pkg::KIND_LITERAL;
                  cmd.e1_len  = rstart_ff;
                  fill_in     = n_val - rstart_ff;
                  rstart_in   = '0;
               end
               runm_in = 1'b1;
            end else if (rstart_ff == '0) begin
               runm_in = 1'b1;
            end
         end else begin
            rstart_in = fill_ff;
         end
      end else begin
         fill_in = n_val;
         if ((req_data_byte != prev_ff) || ((n_val - rstart_ff) > br1rle_pkg::MAX_RUN_LEN)) begin
            // close the run, restart a literal block with this byte
            cmd.e1_kind = br1rle_pkg::KIND_RUN;
            cmd.e1_len  = fill_ff - rstart_ff;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = '0;
            fill_in     = br1rle_pkg::len_type'(1);
            rstart_in   = '0;
            runm_in     = 1'b0;
         end
      end

      if (req_end_of_row) begin
         if (runm_in) begin
            cmd.fl_kind = br1rle_pkg::KIND_RUN;
            cmd.fl_len  = fill_in - rstart_in;
         end else begin
            cmd.fl_kind = br1rle_pkg::KIND_LITERAL;
            cmd.fl_len  = fill_in;
         end
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rstart_ff <= '0;
         runm_ff   <= 1'b0;
         prev_ff   <= '0;
         open_ff   <= 1'b0;
      end else if (q_push) begin
         fill_ff   <= fill_in;
         rstart_ff <= rstart_in;
         runm_ff   <= runm_in;
         prev_ff   <= prev_in;
         open_ff   <= open_in;
      end
   end

endmodule

### design/br1rle_cmd_fifo.sv
// Short command queue between the front end and the back end.
module br1rle_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  br1rle_pkg::cmd_type push_cmd,
   input  logic                pop,
   output br1rle_pkg::cmd_type head_cmd,
   output logic                empty,
   output logic                full
);

   br1rle_pkg::cmd_type    entry_ff [br1rle_pkg::CMDQ_DEPTH];
   br1rle_pkg::qptr_type   wr_ptr_ff;
   br1rle_pkg::qptr_type   rd_ptr_ff;
   br1rle_pkg::qcount_type count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == br1rle_pkg::CMDQ_FULL);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + br1rle_pkg::qptr_type'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + br1rle_pkg::qptr_type'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + br1rle_pkg::qcount_type'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - br1rle_pkg::qcount_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/br1rle_back.sv
// Back end: owns the literal store and turns commands into a stream of code bytes.
module br1rle_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  br1rle_pkg::cmd_type         q_head,
   output logic                        q_pop,
   output br1rle_pkg::byte_stream_type stream,
   input  logic                        take
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_E1_CTRL = 3'd1;
   localparam logic [2:0] PH_E1_BODY = 3'd2;
   localparam logic [2:0] PH_WRITE   = 3'd3;
   localparam logic [2:0] PH_FL_CTRL = 3'd4;
   localparam logic [2:0] PH_FL_BODY = 3'd5;

   logic [2:0]           phase_ff, phase_in, nxt;
   br1rle_pkg::cmd_type  cmd_ff, cmd_in;
   br1rle_pkg::addr_type idx_ff, idx_in;
   logic                 rowpend_ff, rowpend_in;

   // output stage: one code byte, either a literal from the store or a made byte
   logic                 sv_ff;
   logic                 s_mem_ff;
   br1rle_pkg::byte_type sbyte_ff;
   logic                 send_ff;
   logic                 srow_ff;
   logic                 sfirst_ff;
   br1rle_pkg::byte_type mem_q_ff;
   br1rle_pkg::byte_type store_mem [br1rle_pkg::STORE_DEPTH];

   logic                 can_load;
   logic                 load;
   logic                 load_mem;
   br1rle_pkg::byte_type load_byte;
   logic                 load_end;
   logic                 wr_en;
   logic                 done;

   function automatic logic [2:0] after_write(input br1rle_pkg::cmd_type c);
      return (c.fl_kind != br1rle_pkg::KIND_NONE) ? PH_FL_CTRL : PH_IDLE;
   endfunction

   function automatic logic [2:0] after_e1(input br1rle_pkg::cmd_type c);
      return c.wr_en ? PH_WRITE : after_write(c);
   endfunction

   function automatic logic [2:0] first_phase(input br1rle_pkg::cmd_type c);
      return (c.e1_kind != br1rle_pkg::KIND_NONE) ? PH_E1_CTRL : after_e1(c);
   endfunction

   assign can_load = !sv_ff || take;

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      rowpend_in = rowpend_ff;
      q_pop      = 1'b0;
      load       = 1'b0;
      load_mem   = 1'b0;
      load_byte  = '0;
      load_end   = 1'b0;
      wr_en      = 1'b0;
      done       = 1'b0;
      nxt        = PH_IDLE;

      case (phase_ff)
         PH_IDLE: begin
            done = 1'b1;
         end
         PH_E1_CTRL: begin
            if (can_load) begin
               load      = 1'b1;
               load_byte = br1rle_pkg::ctrl_byte(cmd_ff.e1_kind, cmd_ff.e1_len);
               idx_in    = '0;
               phase_in  = PH_E1_BODY;
            end
         end
         PH_E1_BODY: begin
            if (can_load) begin
               load = 1'b1;
               if (cmd_ff.e1_kind == br1rle_pkg::KIND_LITERAL) begin
                  load_mem = 1'b1;
               end else begin
                  load_byte = cmd_ff.e1_byte;
               end
               if ((cmd_ff.e1_kind != br1rle_pkg::KIND_LITERAL) ||
                   (br1rle_pkg::len_type'(idx_in) ==
                    cmd_ff.e1_len - br1rle_pkg::len_type'(1))) begin
                  load_end = (cmd_ff.fl_kind == br1rle_pkg::KIND_NONE);
                  nxt      = after_e1(cmd_ff);
                  if (nxt == PH_IDLE) begin
                     done = 1'b1;
                  end else begin
                     phase_in = nxt;
                  end
               end else begin
                  idx_in = idx_ff + br1rle_pkg::addr_type'(1);
               end
            end
         end
         PH_WRITE: begin
            wr_en = 1'b1;
            nxt   = after_write(cmd_ff);
            if (nxt == PH_IDLE) begin
               done = 1'b1;
            end else begin
               phase_in = nxt;
            end
         end
         PH_FL_CTRL: begin
            if (can_load) begin
               load      = 1'b1;
               load_byte = br1rle_pkg::ctrl_byte(cmd_ff.fl_kind, cmd_ff.fl_len);
               idx_in    = '0;
               phase_in  = PH_FL_BODY;
            end
         end
         PH_FL_BODY: begin
            if (can_load) begin
               load = 1'b1;
               if (cmd_ff.fl_kind == br1rle_pkg::KIND_LITERAL) begin
                  load_mem = 1'b1;
               end else begin
                  load_byte = cmd_ff.data;
               end
               if ((cmd_ff.fl_kind != br1rle_pkg::KIND_LITERAL) ||
                   (br1rle_pkg::len_type'(idx_ff) ==
                    cmd_ff.fl_len - br1rle_pkg::len_type'(1))) begin
                  load_end = 1'b1;
                  done     = 1'b1;
               end else begin
                  idx_in = idx_ff + br1rle_pkg::addr_type'(1);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // the byte loaded now belongs to the current command
      if (load) begin
         rowpend_in = 1'b0;
      end

      // command finished: take the next one in the same cycle
      if (done) begin
         if (!q_empty) begin
            q_pop    = 1'b1;
            cmd_in   = q_head;
            phase_in = first_phase(q_head);
            if (q_head.row_start) begin
               rowpend_in = 1'b1;
            end
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         rowpend_ff <= 1'b0;
         sv_ff      <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         rowpend_ff <= rowpend_in;
         if (load) begin
            sv_ff <= 1'b1;
         end else if (take) begin
            sv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (load) begin
         s_mem_ff  <= load_mem;
         sbyte_ff  <= load_byte;
         send_ff   <= load_end;
         srow_ff   <= load_end && cmd_ff.last;
         sfirst_ff <= rowpend_ff;
      end
   end

   // literal store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[cmd_ff.wr_addr] <= cmd_ff.data;
      end
      if (load_mem) begin
         mem_q_ff <= store_mem[idx_ff];
      end
   end

   assign stream.valid     = sv_ff;
   assign stream.data      = s_mem_ff ? mem_q_ff : sbyte_ff;
   assign stream.step_end  = send_ff;
   assign stream.row_end   = srow_ff;
   assign stream.row_first = sfirst_ff;

`ifndef NO_ASSERTIONS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && load_mem))
      else $error("store written and read in the same cycle");

   a_literal_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_E1_BODY && cmd_ff.e1_kind == br1rle_pkg::KIND_LITERAL) |->
      (br1rle_pkg::len_type'(idx_ff) < cmd_ff.e1_len))
      else $error("literal read index beyond block length");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (sv_ff && !take) |=> (sv_ff && $stable(mem_q_ff) && $stable(sbyte_ff)))
      else $error("held code byte changed");
`endif

endmodule

### design/br1rle_packer.sv
// Packer: gathers code bytes into lanes and holds the result register.
module br1rle_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  br1rle_pkg::byte_stream_type stream,
   output logic                        take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_code_lanes,
   output logic [3:0]                  rsp_lane_count,
   output logic                        rsp_row_finished,
   output logic [16:0]                 rsp_packed_total
);

   br1rle_pkg::lanes_type lanes_ff, lanes_in;
   br1rle_pkg::count_type cnt_ff, cnt_in;
   br1rle_pkg::total_type total_ff, total_in;
   logic                  rsp_valid_ff;
   br1rle_pkg::lanes_type rsp_lanes_ff;
   br1rle_pkg::count_type rsp_count_ff;
   logic                  rsp_fin_ff;
   br1rle_pkg::total_type rsp_total_ff;
   logic                  close;
   logic                  out_free;

   assign close    = (cnt_ff == br1rle_pkg::LAST_LANE) || stream.step_end;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = stream.valid && (!close || out_free);
   assign cnt_in   = cnt_ff + br1rle_pkg::count_type'(1);

   always_comb begin
      lanes_in = lanes_ff;
      for (int i = 0; i < br1rle_pkg::OUT_LANES; i++) begin
         if (cnt_ff == br1rle_pkg::count_type'(i)) begin
            lanes_in[8*i +: 8] = stream.data;
         end
      end
      if (stream.row_first) begin
         total_in = br1rle_pkg::total_type'(1);
      end else if (total_ff == br1rle_pkg::TOTAL_MAX) begin
         total_in = total_ff;
      end else begin
         total_in = total_ff + br1rle_pkg::total_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff     <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            total_ff <= total_in;
            if (close) begin
               lanes_ff <= '0;
               cnt_ff   <= '0;
            end else begin
               lanes_ff <= lanes_in;
               cnt_ff   <= cnt_in;
            end
         end
         if (take && close) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && close) begin
         rsp_lanes_ff <= lanes_in;
         rsp_count_ff <= cnt_in;
         rsp_fin_ff   <= stream.row_end;
         rsp_total_ff <= stream.row_end ? total_in : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_lanes   = rsp_lanes_ff;
   assign rsp_lane_count   = rsp_count_ff;
   assign rsp_row_finished = rsp_fin_ff;
   assign rsp_packed_total = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0 && rsp_count_ff <= br1rle_pkg::OUT_LANES_CNT))
      else $error("result lane count out of range");

   a_total_only_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_fin_ff) |-> (rsp_total_ff == '0))
      else $error("packed total on a result that does not close a row");
`endif

endmodule
